/* hdl/tps_pkg.sv */
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants of the touch event to pointer scaler
// Event codes, register indexes, field widths and the divider status struct.
// ----------------------------------------------------------------------------
package tps_pkg;

	localparam int VALUE_WIDTH_DEF = 16;

	localparam int KIND_W   = 5;
	localparam int CODE_W   = 10;
	localparam int CAL_W    = 16;
	localparam int SCREEN_W = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// span is the difference of two calibration values
	localparam int SPAN_W = CAL_W + 1;
	// quotient: 14 magnitude bits and one overflow bit
	localparam int QUO_W  = 15;
	localparam int MAG_W  = QUO_W - 1;
	localparam int CNT_W  = 4;
	// divisor shifted up to the top quotient bit
	localparam int DIVS_W = SPAN_W + QUO_W - 1;

	localparam logic [KIND_W-1:0] EV_SYNC = 5'd0;
	localparam logic [KIND_W-1:0] EV_KEY  = 5'd1;
	localparam logic [KIND_W-1:0] EV_ABS  = 5'd3;

	localparam logic [CODE_W-1:0] ABS_X     = 10'd0;
	localparam logic [CODE_W-1:0] ABS_Y     = 10'd1;
	localparam logic [CODE_W-1:0] KEY_TOUCH = 10'd330;

	localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H  = 3'd5;

	localparam logic signed [CAL_W-1:0] CAL_MIN_RST = 16'sd0;
	localparam logic signed [CAL_W-1:0] CAL_MAX_RST = 16'sd4095;
	localparam logic [SCREEN_W-1:0] SCREEN_W_RST = 13'd320;
	localparam logic [SCREEN_W-1:0] SCREEN_H_RST = 13'd240;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_stat_t;

endpackage

/* hdl/tps_if.sv */
// ----------------------------------------------------------------------------
// tps_if: channel interfaces of the touch event to pointer scaler
// Event input, pointer result and configuration write channels.
// ----------------------------------------------------------------------------
interface tps_event_if #(parameter int VALUE_WIDTH = tps_pkg::VALUE_WIDTH_DEF);
	logic                                valid;
	logic                                ready;
	logic [tps_pkg::KIND_W-1:0]          event_kind;
	logic [tps_pkg::CODE_W-1:0]          event_code;
	logic signed [VALUE_WIDTH-1:0]       event_value;

	modport source (output valid, event_kind, event_code, event_value, input ready);
	modport sink   (input valid, event_kind, event_code, event_value, output ready);
endinterface

interface tps_pointer_if;
	logic                           valid;
	logic                           ready;
	logic [tps_pkg::SCREEN_W-1:0]   pointer_x;
	logic [tps_pkg::SCREEN_W-1:0]   pointer_y;
	logic                           left_button;
	logic                           span_error;

	modport source (output valid, pointer_x, pointer_y, left_button, span_error,
		input ready);
	modport sink   (input valid, pointer_x, pointer_y, left_button, span_error,
		output ready);
endinterface

interface tps_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [tps_pkg::CFG_IDX_W-1:0]    index;
	logic [tps_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/touch_event_to_pointer_scaler.sv */
// ----------------------------------------------------------------------------
// touch_event_to_pointer_scaler: touchscreen events to pointer positions
// Latches raw X, Y and touch state; on sync scales both axes to the screen.
// ----------------------------------------------------------------------------
// Channels: evt takes one event item (kind, code, value) per handshake; ptr
// gives one pointer item for every sync event; cfg writes the calibration
// and screen registers by index (cfg.ready is always high, unknown indexes
// are dropped). Write cfg only while no sync item is in flight.
// Axis and key events are taken one per cycle while the block is idle and
// give no result. A sync event runs both axes through one multiplier and
// one shared restoring divider, one quotient bit per cycle: per axis a
// multiply step, a load step, 15 divide steps and a finish step that
// stores the axis result. After a sync item is accepted, evt.ready stays
// low until its result is in the output register, so no new item is taken
// while it is in flight; the pace is set by the divider's bit-serial loop.
// The output register holds a result while ptr.ready is low; the next events
// are still taken, and a following sync waits for the register before it
// finishes. Reset clears the latched values, the touch state and the output
// valid, and restores the default calibration (0..4095) and 320x240 screen.
// ----------------------------------------------------------------------------
module touch_event_to_pointer_scaler #(
	parameter int VALUE_WIDTH = tps_pkg::VALUE_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	tps_event_if.sink        evt,
	tps_pointer_if.source    ptr,
	tps_cfg_if.sink          cfg
);

	localparam int AW = (VALUE_WIDTH > tps_pkg::CAL_W) ? VALUE_WIDTH : tps_pkg::CAL_W;
	localparam int DW = AW + 1;
	localparam int PW = DW + tps_pkg::SCREEN_W + 1;
	localparam int RW = (PW > tps_pkg::DIVS_W) ? PW : tps_pkg::DIVS_W;
	localparam int SW = tps_pkg::SCREEN_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	logic       axis_q;

	logic signed [tps_pkg::CAL_W-1:0] cal_min_x_q, cal_max_x_q, cal_min_y_q, cal_max_y_q;
	logic [SW-1:0]                    screen_w_q, screen_h_q;
	logic signed [VALUE_WIDTH-1:0]    latched_x_q, latched_y_q;
	logic                             touch_q;

	logic signed [PW-1:0]             prod_q;
	logic [tps_pkg::SPAN_W-1:0]       span_mag_q;
	logic                             span_neg_q;
	logic                             zero_q;
	logic                             qneg_q;
	logic [SW-1:0]                    res_x_q, res_y_q;
	logic                             err_q;

	logic                             out_valid_q;
	logic [SW-1:0]                    out_x_q, out_y_q;
	logic                             out_btn_q, out_err_q;

	logic                             accept;
	logic                             out_load;
	logic signed [tps_pkg::CAL_W-1:0] cal_min_sel, cal_max_sel;
	logic signed [VALUE_WIDTH-1:0]    latch_sel;
	logic [SW-1:0]                    screen_sel;
	logic signed [DW-1:0]             diff;
	logic signed [tps_pkg::SPAN_W-1:0] span;
	logic signed [PW-1:0]             prod;
	logic [PW-1:0]                    prod_mag;
	logic                             div_start;
	tps_pkg::div_stat_t               div_stat;
	logic [tps_pkg::MAG_W-1:0]        quo;
	logic                             big;
	logic [SW-1:0]                    axis_res;

	assign evt.ready = (state_q == S_IDLE);
	assign accept    = evt.valid && evt.ready;
	assign cfg.ready = 1'b1;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || ptr.ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_min_x_q <= tps_pkg::CAL_MIN_RST;
			cal_max_x_q <= tps_pkg::CAL_MAX_RST;
			cal_min_y_q <= tps_pkg::CAL_MIN_RST;
			cal_max_y_q <= tps_pkg::CAL_MAX_RST;
			screen_w_q  <= tps_pkg::SCREEN_W_RST;
			screen_h_q  <= tps_pkg::SCREEN_H_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tps_pkg::REG_CAL_MIN_X: cal_min_x_q <= $signed(cfg.data);
				tps_pkg::REG_CAL_MAX_X: cal_max_x_q <= $signed(cfg.data);
				tps_pkg::REG_CAL_MIN_Y: cal_min_y_q <= $signed(cfg.data);
				tps_pkg::REG_CAL_MAX_Y: cal_max_y_q <= $signed(cfg.data);
				tps_pkg::REG_SCREEN_W:  screen_w_q  <= cfg.data[SW-1:0];
				tps_pkg::REG_SCREEN_H:  screen_h_q  <= cfg.data[SW-1:0];
				default: ;
			endcase
		end
	end

	// latched touch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_x_q <= '0;
			latched_y_q <= '0;
			touch_q     <= 1'b0;
		end else if (accept) begin
			if (evt.event_kind == tps_pkg::EV_ABS) begin
				if (evt.event_code == tps_pkg::ABS_X) begin
					latched_x_q <= evt.event_value;
				end else if (evt.event_code == tps_pkg::ABS_Y) begin
					latched_y_q <= evt.event_value;
				end
			end else if (evt.event_kind == tps_pkg::EV_KEY) begin
				if (evt.event_code == tps_pkg::KEY_TOUCH) begin
					touch_q <= (evt.event_value != '0);
				end
			end
		end
	end

	// axis operand selection and the shared multiplier
	assign cal_min_sel = axis_q ? cal_min_y_q : cal_min_x_q;
	assign cal_max_sel = axis_q ? cal_max_y_q : cal_max_x_q;
	assign latch_sel   = axis_q ? latched_y_q : latched_x_q;
	assign screen_sel  = axis_q ? screen_h_q  : screen_w_q;

	assign diff = DW'(latch_sel) - DW'(cal_min_sel);
	assign span = tps_pkg::SPAN_W'(cal_max_sel) - tps_pkg::SPAN_W'(cal_min_sel);
	assign prod = PW'(diff) * PW'($signed({1'b0, screen_sel}));

	assign prod_mag  = prod_q[PW-1] ? PW'(~prod_q + 1'b1) : PW'(prod_q);
	assign div_start = (state_q == S_LOAD);

	tps_div #(
		.RW (RW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (RW'(prod_mag)),
		.divisor  (span_mag_q),
		.stat     (div_stat),
		.quotient (quo)
	);

	// clamp the truncated quotient to 0..screen, invert for Y
	assign big = div_stat.ovf || (quo > tps_pkg::MAG_W'(screen_sel));

	always_comb begin
		if (zero_q) begin
			axis_res = '0;
		end else if (!axis_q) begin
			priority if (qneg_q) axis_res = '0;
			else if (big)        axis_res = screen_sel;
			else                 axis_res = quo[SW-1:0];
		end else begin
			priority if (qneg_q) axis_res = screen_sel;
			else if (big)        axis_res = '0;
			else                 axis_res = screen_sel - quo[SW-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && evt.event_kind == tps_pkg::EV_SYNC) begin
						axis_q  <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL:  state_q <= S_LOAD;
				S_LOAD: state_q <= S_DIV;
				S_DIV: begin
					if (div_stat.done) begin
						if (!axis_q) begin
							axis_q  <= 1'b1;
							state_q <= S_MUL;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= 1'b0;
		end
		if (state_q == S_MUL) begin
			prod_q     <= prod;
			span_neg_q <= span[tps_pkg::SPAN_W-1];
			span_mag_q <= span[tps_pkg::SPAN_W-1] ? tps_pkg::SPAN_W'(-span)
			                                      : tps_pkg::SPAN_W'(span);
			zero_q     <= (span == '0);
		end
		if (state_q == S_LOAD) begin
			qneg_q <= prod_q[PW-1] ^ span_neg_q;
		end
		if (state_q == S_DIV && div_stat.done) begin
			if (!axis_q) begin
				res_x_q <= axis_res;
			end else begin
				res_y_q <= axis_res;
			end
			if (zero_q) begin
				err_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (ptr.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q   <= res_x_q;
			out_y_q   <= res_y_q;
			out_btn_q <= touch_q;
			out_err_q <= err_q;
		end
	end

	assign ptr.valid       = out_valid_q;
	assign ptr.pointer_x   = out_x_q;
	assign ptr.pointer_y   = out_y_q;
	assign ptr.left_button = out_btn_q;
	assign ptr.span_error  = out_err_q;

endmodule

/* hdl/tps_div.sv */
// ----------------------------------------------------------------------------
// tps_div: iterative restoring divider
// One quotient bit per cycle, top bit flags a quotient beyond the magnitude.
// ----------------------------------------------------------------------------
module tps_div #(
	parameter int RW = tps_pkg::DIVS_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [RW-1:0]                 dividend,
	input  logic [tps_pkg::SPAN_W-1:0]    divisor,
	output tps_pkg::div_stat_t            stat,
	output logic [tps_pkg::MAG_W-1:0]     quotient
);

	logic [RW-1:0]                 rem_q;
	logic [RW-1:0]                 dvs_q;
	logic [tps_pkg::QUO_W-1:0]     quo_q;
	logic [tps_pkg::CNT_W-1:0]     cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic                          ge;

	assign ge = rem_q >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tps_pkg::CNT_W'(tps_pkg::QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= RW'({divisor, {(tps_pkg::QUO_W-1){1'b0}}});
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q;
			end
			quo_q <= {quo_q[tps_pkg::QUO_W-2:0], ge};
			dvs_q <= dvs_q >> 1;
		end
	end

	assign stat.done = done_q;
	assign stat.ovf  = quo_q[tps_pkg::QUO_W-1];
	assign quotient  = quo_q[tps_pkg::MAG_W-1:0];

endmodule

/* hdl/tps_checker.sv */
// ----------------------------------------------------------------------------
// tps_checker: port-level checks of the touch event to pointer scaler
// Watches the event and pointer channels; bound to the top level.
// ----------------------------------------------------------------------------
module tps_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           evt_valid,
	input  logic                           evt_ready,
	input  logic [tps_pkg::KIND_W-1:0]     evt_kind,
	input  logic                           ptr_valid,
	input  logic                           ptr_ready,
	input  logic [tps_pkg::SCREEN_W-1:0]   ptr_x,
	input  logic [tps_pkg::SCREEN_W-1:0]   ptr_y,
	input  logic                           ptr_btn,
	input  logic                           ptr_err
);

	// a sync item occupies the block: no item is taken in the next cycle
	a_sync_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt_ready && evt_kind == tps_pkg::EV_SYNC) |=> !evt_ready)
		else $error("item accepted right after a sync item");

	// axis and key items never produce a pointer item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt_ready && evt_kind != tps_pkg::EV_SYNC && !ptr_valid)
		|=> !ptr_valid)
		else $error("pointer item appeared after a non-sync item");

	// hold the pointer item while the receiver stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_valid && !ptr_ready) |=> (ptr_valid && $stable({ptr_x, ptr_y, ptr_btn, ptr_err})))
		else $error("stalled pointer item changed or dropped");

	a_reset: assert property (@(posedge clk) !arst_n |-> !ptr_valid)
		else $error("pointer valid during reset");

endmodule

bind touch_event_to_pointer_scaler tps_checker u_tps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (evt.valid),
	.evt_ready (evt.ready),
	.evt_kind  (evt.event_kind),
	.ptr_valid (ptr.valid),
	.ptr_ready (ptr.ready),
	.ptr_x     (ptr.pointer_x),
	.ptr_y     (ptr.pointer_y),
	.ptr_btn   (ptr.left_button),
	.ptr_err   (ptr.span_error)
);
